// ===== hw/rtl/eil4hp_pkg.sv =====
`default_nettype none

package eil4hp_pkg;

    // Frame offsets are 16 bits wide
    localparam int OffsetWidth = 16;

    // Layer-3 EtherType values
    localparam logic [15:0] TYPE_IPV4 = 16'h0800;
    localparam logic [15:0] TYPE_IPV6 = 16'h86DD;

    // Transport protocol numbers
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    // Layer-3 start for untagged, single-tag and double-tag frames
    localparam logic [4:0] L3_UNTAGGED   = 5'd14;
    localparam logic [4:0] L3_SINGLE_TAG = 5'd18;
    localparam logic [4:0] L3_DOUBLE_TAG = 5'd22;

    // Fixed header sizes
    localparam logic [5:0] IPV4_MIN_HDR = 6'd20;
    localparam logic [6:0] IPV6_HDR     = 7'd40;
    localparam logic [5:0] UDP_HDR      = 6'd8;
    localparam logic [5:0] ICMP_HDR     = 6'd8;

    // Result status codes
    localparam logic [2:0] STATUS_OK          = 3'd0;
    localparam logic [2:0] STATUS_NOT_IP      = 3'd1;
    localparam logic [2:0] STATUS_FRAME_SHORT = 3'd2;
    localparam logic [2:0] STATUS_IPV4_SHORT  = 3'd3;
    localparam logic [2:0] STATUS_BAD_IHL     = 3'd4;
    localparam logic [2:0] STATUS_IPV6_SHORT  = 3'd5;

    // Register select (paddr bit 2)
    localparam logic REG_SINGLE_TAG = 1'b0;
    localparam logic REG_DOUBLE_TAG = 1'b1;

    // Register reset values
    localparam logic [15:0] SINGLE_TAG_RESET = 16'h88A8;
    localparam logic [15:0] DOUBLE_TAG_RESET = 16'h9100;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        is_ipv6;
        logic [63:0] source_high;
        logic [63:0] source_low;
        logic [63:0] dest_high;
        logic [63:0] dest_low;
        logic [7:0]  protocol;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [15:0] payload_length;
    } out_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ethernet_ip_l4_header_parser_top.sv =====
`default_nettype none
// Ethernet / IPv4 / IPv6 / TCP / UDP / ICMP header parser.
// Input channel (in_valid, in_stall, in_data): one frame byte per request, in
// wire order, with last_byte set on the final byte of the frame.
// Output channel (out_valid, out_stall, out_data): one result per frame,
// carrying status, addresses, protocol, ports and layer-4 payload length.
// APB port: register 0 (byte address 0) is the single-tag EtherType, register
// 1 (byte address 4) the double-tag EtherType; write only while idle.
// Throughput: one byte per cycle across frame boundaries, except while a
// final byte waits behind a stalled result.
// A frame's result is built from the input register and loaded into the
// result register when its last byte advances; out_valid rises right after.
// A byte is parsed in the cycle after it is accepted; per-frame state is
// updated by offset compares only, so nothing iterates.
// When the receiver stalls, the held result stays put; further non-final
// bytes keep flowing, and in_stall rises only when a final byte waits for
// the output register to free up.
// Reset clears the per-frame state, empties both registers and restores the
// tag EtherTypes to 0x88A8 and 0x9100.

module ethernet_ip_l4_header_parser_top #(
    parameter int MAX_FRAME = 65535
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Frame byte input
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire eil4hp_pkg::in_item_t  in_data,
    // Parse result output
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output eil4hp_pkg::out_item_t      out_data,
    // Configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam logic [eil4hp_pkg::OffsetWidth-1:0] MaxFrameW =
        eil4hp_pkg::OffsetWidth'(MAX_FRAME);

    // Configuration registers
    logic [15:0] single_tag_reg;
    logic [15:0] double_tag_reg;

    // Input register
    logic                 in_valid_reg;
    eil4hp_pkg::in_item_t in_item_reg;

    // Per-frame state
    logic [15:0] byte_offset_reg,  byte_offset_next;
    logic [15:0] ether_kind_reg,   ether_kind_next;
    logic [4:0]  layer3_start_reg, layer3_start_next;
    logic [6:0]  layer4_start_reg, layer4_start_next;
    logic [5:0]  ip_hdr_len_reg,   ip_hdr_len_next;
    logic [7:0]  proto_reg,        proto_next;
    logic [63:0] source_addr_reg  [2];
    logic [63:0] source_addr_next [2];
    logic [63:0] dest_addr_reg  [2];
    logic [63:0] dest_addr_next [2];
    logic [15:0] port_word_reg  [2];
    logic [15:0] port_word_next [2];
    logic [3:0]  tcp_doff_reg,     tcp_doff_next;

    // Output register
    logic                  out_valid_reg;
    eil4hp_pkg::out_item_t out_item_reg;
    eil4hp_pkg::out_item_t result;

    logic advance;
    logic cfg_write;

    // Handshakes
    assign advance  = in_valid_reg
                   && !(in_item_reg.last_byte && out_valid_reg && out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // APB port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            eil4hp_pkg::REG_SINGLE_TAG: prdata = {16'b0, single_tag_reg};
            eil4hp_pkg::REG_DOUBLE_TAG: prdata = {16'b0, double_tag_reg};
            default:                    prdata = 32'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            single_tag_reg <= eil4hp_pkg::SINGLE_TAG_RESET;
            double_tag_reg <= eil4hp_pkg::DOUBLE_TAG_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == eil4hp_pkg::REG_SINGLE_TAG)
                single_tag_reg <= pwdata[15:0];
            else
                double_tag_reg <= pwdata[15:0];
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_item_reg <= in_data;
    end

    // Byte parse and result build
    always_comb
    begin
        logic [7:0]  b;
        logic [15:0] o;
        logic [15:0] l3w;
        logic [15:0] r;
        logic [15:0] l;
        logic [15:0] len;
        logic [15:0] l4len;
        logic [5:0]  hdr;
        logic [15:0] sp;
        logic [15:0] dp;
        logic [2:0]  status;
        logic        k;
        logic        is_v4;
        logic        is_v6;

        b   = in_item_reg.frame_byte;
        o   = byte_offset_reg;
        r   = 16'd0;
        l   = 16'd0;
        k   = 1'b0;

        ether_kind_next   = ether_kind_reg;
        layer3_start_next = layer3_start_reg;
        layer4_start_next = layer4_start_reg;
        ip_hdr_len_next   = ip_hdr_len_reg;
        proto_next        = proto_reg;
        source_addr_next  = source_addr_reg;
        dest_addr_next    = dest_addr_reg;
        port_word_next    = port_word_reg;
        tcp_doff_next     = tcp_doff_reg;
        byte_offset_next  = byte_offset_reg;

        if (o < MaxFrameW)
        begin
            // EtherType, re-read after tags
            l3w = 16'(layer3_start_next);
            if (o == l3w - 16'd2)
                ether_kind_next = {b, ether_kind_next[7:0]};
            if (o == l3w - 16'd1)
            begin
                ether_kind_next = {ether_kind_next[15:8], b};
                if (o == 16'd13)
                begin
                    if (ether_kind_next == single_tag_reg)
                        layer3_start_next = eil4hp_pkg::L3_SINGLE_TAG;
                    else if (ether_kind_next == double_tag_reg)
                        layer3_start_next = eil4hp_pkg::L3_DOUBLE_TAG;
                end
            end

            // Layer-3 header
            l3w = 16'(layer3_start_next);
            r   = o - l3w;
            if (o >= l3w)
            begin
                if (ether_kind_next == eil4hp_pkg::TYPE_IPV4)
                begin
                    if (r == 16'd0)
                    begin
                        ip_hdr_len_next   = {b[3:0], 2'b00};
                        layer4_start_next = 7'(layer3_start_next) + 7'(ip_hdr_len_next);
                    end
                    else if (r == 16'd9)
                        proto_next = b;
                    else if (r >= 16'd12 && r < 16'd16)
                        source_addr_next[1] = {32'b0, source_addr_next[1][23:0], b};
                    else if (r >= 16'd16 && r < 16'd20)
                        dest_addr_next[1] = {32'b0, dest_addr_next[1][23:0], b};
                end
                else if (ether_kind_next == eil4hp_pkg::TYPE_IPV6)
                begin
                    if (r == 16'd0)
                        layer4_start_next = 7'(layer3_start_next) + eil4hp_pkg::IPV6_HDR;
                    else if (r == 16'd6)
                        proto_next = b;
                    else if (r >= 16'd8 && r < 16'd24)
                    begin
                        k = (r >= 16'd16);
                        source_addr_next[k] = {source_addr_next[k][55:0], b};
                    end
                    else if (r >= 16'd24 && r < 16'd40)
                    begin
                        k = (r >= 16'd32);
                        dest_addr_next[k] = {dest_addr_next[k][55:0], b};
                    end
                end
            end

            // Transport header: ports and TCP data offset
            l = o - 16'(layer4_start_next);
            if (layer4_start_next != 7'd0 && o >= 16'(layer4_start_next))
            begin
                if (l < 16'd4)
                begin
                    k = l[1];
                    port_word_next[k] = {port_word_next[k][7:0], b};
                end
                else if (l == 16'd12)
                    tcp_doff_next = b[7:4];
            end

            byte_offset_next = o + 16'd1;
        end

        // Status checks, in priority order
        len   = byte_offset_next;
        l3w   = 16'(layer3_start_next);
        is_v4 = (ether_kind_next == eil4hp_pkg::TYPE_IPV4);
        is_v6 = (ether_kind_next == eil4hp_pkg::TYPE_IPV6);
        priority if (len < l3w)
            status = eil4hp_pkg::STATUS_FRAME_SHORT;
        else if (!is_v4 && !is_v6)
            status = eil4hp_pkg::STATUS_NOT_IP;
        else if (is_v4 && len < l3w + 16'd20)
            status = eil4hp_pkg::STATUS_IPV4_SHORT;
        else if (is_v4 && ip_hdr_len_next < eil4hp_pkg::IPV4_MIN_HDR)
            status = eil4hp_pkg::STATUS_BAD_IHL;
        else if (is_v6 && len < l3w + 16'(eil4hp_pkg::IPV6_HDR))
            status = eil4hp_pkg::STATUS_IPV6_SHORT;
        else
            status = eil4hp_pkg::STATUS_OK;

        // Ports and transport header size by protocol
        l4len = (len > 16'(layer4_start_next)) ? len - 16'(layer4_start_next) : 16'd0;
        priority if (proto_next == eil4hp_pkg::PROTO_TCP)
        begin
            sp  = port_word_next[0];
            dp  = port_word_next[1];
            hdr = {tcp_doff_next, 2'b00};
        end
        else if (proto_next == eil4hp_pkg::PROTO_UDP)
        begin
            sp  = port_word_next[0];
            dp  = port_word_next[1];
            hdr = eil4hp_pkg::UDP_HDR;
        end
        else if (proto_next == eil4hp_pkg::PROTO_ICMP)
        begin
            sp  = {8'b0, port_word_next[0][15:8]};
            dp  = {8'b0, port_word_next[0][7:0]};
            hdr = eil4hp_pkg::ICMP_HDR;
        end
        else
        begin
            sp  = 16'd0;
            dp  = 16'd0;
            hdr = 6'd0;
        end

        // Error results carry nothing but the status
        result        = '0;
        result.status = status;
        if (status == eil4hp_pkg::STATUS_OK)
        begin
            result.is_ipv6        = is_v6;
            result.source_high    = source_addr_next[0];
            result.source_low     = source_addr_next[1];
            result.dest_high      = dest_addr_next[0];
            result.dest_low       = dest_addr_next[1];
            result.protocol       = proto_next;
            result.source_port    = sp;
            result.dest_port      = dp;
            result.payload_length = (l4len > 16'(hdr)) ? l4len - 16'(hdr) : 16'd0;
        end
    end

    // Frame state: updated per byte, cleared after the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_offset_reg  <= '0;
            ether_kind_reg   <= '0;
            layer3_start_reg <= eil4hp_pkg::L3_UNTAGGED;
            layer4_start_reg <= '0;
            ip_hdr_len_reg   <= '0;
            proto_reg        <= '0;
            source_addr_reg  <= '{default: '0};
            dest_addr_reg    <= '{default: '0};
            port_word_reg    <= '{default: '0};
            tcp_doff_reg     <= '0;
        end
        else if (advance)
        begin
            if (in_item_reg.last_byte)
            begin
                byte_offset_reg  <= '0;
                ether_kind_reg   <= '0;
                layer3_start_reg <= eil4hp_pkg::L3_UNTAGGED;
                layer4_start_reg <= '0;
                ip_hdr_len_reg   <= '0;
                proto_reg        <= '0;
                source_addr_reg  <= '{default: '0};
                dest_addr_reg    <= '{default: '0};
                port_word_reg    <= '{default: '0};
                tcp_doff_reg     <= '0;
            end
            else
            begin
                byte_offset_reg  <= byte_offset_next;
                ether_kind_reg   <= ether_kind_next;
                layer3_start_reg <= layer3_start_next;
                layer4_start_reg <= layer4_start_next;
                ip_hdr_len_reg   <= ip_hdr_len_next;
                proto_reg        <= proto_next;
                source_addr_reg  <= source_addr_next;
                dest_addr_reg    <= dest_addr_next;
                port_word_reg    <= port_word_next;
                tcp_doff_reg     <= tcp_doff_next;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && in_item_reg.last_byte)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_item_reg.last_byte)
            out_item_reg <= result;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/eil4hp_checker.sv =====
`default_nettype none

module eil4hp_checker (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_stall,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire eil4hp_pkg::out_item_t out_data
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

    // Input backs up only behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

    // Error results carry only the status
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != eil4hp_pkg::STATUS_OK |->
            out_data.is_ipv6 == 1'b0 && out_data.source_high == 64'd0
            && out_data.source_low == 64'd0 && out_data.dest_high == 64'd0
            && out_data.dest_low == 64'd0 && out_data.protocol == 8'd0
            && out_data.source_port == 16'd0 && out_data.dest_port == 16'd0
            && out_data.payload_length == 16'd0)
    else $error("error result has nonzero fields");

    // IPv4 addresses sit in the low 32 bits only
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == eil4hp_pkg::STATUS_OK && !out_data.is_ipv6 |->
            out_data.source_high == 64'd0 && out_data.dest_high == 64'd0
            && out_data.source_low[63:32] == 32'd0
            && out_data.dest_low[63:32] == 32'd0)
    else $error("IPv4 result has high address bits");

endmodule

bind ethernet_ip_l4_header_parser_top eil4hp_checker u_eil4hp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire
